>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

>>> hw/rtl/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Types and constants shared by the byte shuffle/transpose block.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int CAPACITY_DEF     = 4096;
  localparam int MAX_ELEMENT_SIZE = 16;

  localparam int BYTE_W     = 8;
  localparam int SIZE_W     = 5;
  localparam int COUNT_W    = 13;
  localparam int TOTAL_W    = SIZE_W + COUNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEMENT_SIZE  = 2'd0,
    REG_ELEMENT_COUNT = 2'd1,
    REG_DIRECTION     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic {
    DIR_SHUFFLE   = 1'b0,
    DIR_UNSHUFFLE = 1'b1
  } dir_t;

  localparam logic [SIZE_W-1:0]  SIZE_RST  = 5'd4;
  localparam logic [COUNT_W-1:0] COUNT_RST = 13'd1024;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
    dir_t               dir;
    logic [TOTAL_W-1:0] total;
    logic               ok;
  } cfg_t;

  typedef struct packed {
    logic err;
    logic last;
  } rd_meta_t;

endpackage

>>> hw/rtl/bst_in_if.sv
// ----------------------------------------------------------------------------
// bst_in_if
// Input channel: load or read request with its byte.
// ----------------------------------------------------------------------------
interface bst_in_if;
  import bst_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface

>>> hw/rtl/bst_out_if.sv
// ----------------------------------------------------------------------------
// bst_out_if
// Result channel: one permuted byte with last and error flags.
// ----------------------------------------------------------------------------
interface bst_out_if;
  import bst_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              out_error;

  modport source (output valid, output out_byte, output out_last, output out_error,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_error,
                  output ready);
endinterface

>>> hw/rtl/byte_shuffle_transpose_top.sv
// ----------------------------------------------------------------------------
// byte_shuffle_transpose_top
// Byte shuffle/unshuffle of one block held in a single-port buffer.
// Read path: a read's byte is captured in the buffer's read register, then
// moves into the output register once the output slot is free.
// Throughput: one transaction per cycle, set by the single buffer port, unless a read result waits on a stalled output.
// Reset: positions and counters cleared, registers to defaults; buffer
// contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_shuffle_transpose_top #(
  parameter int CAPACITY = bst_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bst_in_if.sink                          in_if,
  bst_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [bst_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bst_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bst_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);

  cfg_t              cfg;
  rd_meta_t          meta;
  rd_meta_t          pend_meta_r;
  logic              go, move;
  logic              mem_en, mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r, out_error_r;

  bst_cfg #(.CAPACITY(CAPACITY)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bst_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .go        (go),
    .action    (in_if.action),
    .in_byte   (in_if.in_byte),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .meta      (meta)
  );

  bst_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // read data waits in the buffer's output register until the output slot frees
  assign move        = pend_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !pend_r || move;
  assign go          = in_if.valid && in_if.ready;

  always_comb begin
    pend_nxt = pend_r;
    if (move) begin
      pend_nxt = 1'b0;
    end
    if (go && (in_if.action == ACT_READ)) begin
      pend_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (in_if.action == ACT_READ)) begin
      pend_meta_r <= meta;
    end
    if (move) begin
      out_byte_r  <= pend_meta_r.err ? '0 : mem_rdata;
      out_last_r  <= pend_meta_r.last;
      out_error_r <= pend_meta_r.err;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_byte  = out_byte_r;
  assign out_if.out_last  = out_last_r;
  assign out_if.out_error = out_error_r;

  `ASSERT_NEVER(a_err_clean, clk, rst_n, out_valid_r && out_error_r && ((out_byte_r != '0) || out_last_r), "error result carries data")
  `ASSERT_NEVER(a_no_overrun, clk, rst_n, mem_en && !mem_we && pend_r && !move, "buffer read while previous data unconsumed")
  `ASSERT_PROP(a_pend_hold, clk, rst_n, pend_r && !move |=> pend_r, "pending read data dropped")

endmodule

>>> hw/rtl/bst_cfg.sv
// ----------------------------------------------------------------------------
// bst_cfg
// Configuration registers, block size product and validity check.
// ----------------------------------------------------------------------------
module bst_cfg #(
  parameter int CAPACITY = bst_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bst_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output bst_pkg::cfg_t                   cfg
);
  import bst_pkg::*;

  logic [SIZE_W-1:0]  size_r,  size_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  dir_t               dir_r,   dir_nxt;
  logic [TOTAL_W-1:0] total;

  always_comb begin
    size_nxt  = size_r;
    count_nxt = count_r;
    dir_nxt   = dir_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_ELEMENT_SIZE:  size_nxt  = cfg_wdata[SIZE_W-1:0];
        REG_ELEMENT_COUNT: count_nxt = cfg_wdata[COUNT_W-1:0];
        REG_DIRECTION:     dir_nxt   = dir_t'(cfg_wdata[0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_RST;
      count_r <= COUNT_RST;
      dir_r   <= DIR_SHUFFLE;
    end else begin
      size_r  <= size_nxt;
      count_r <= count_nxt;
      dir_r   <= dir_nxt;
    end
  end

  assign total = TOTAL_W'(size_r) * TOTAL_W'(count_r);

  always_comb begin
    cfg.size  = size_r;
    cfg.count = count_r;
    cfg.dir   = dir_r;
    cfg.total = total;
    cfg.ok    = (size_r != '0) && (32'(size_r) <= MAX_ELEMENT_SIZE) &&
                (count_r != '0) && (32'(total) <= CAPACITY);
  end

endmodule

>>> hw/rtl/bst_mem.sv
// ----------------------------------------------------------------------------
// bst_mem
// Single-port block buffer, synchronous read with registered data.
// ----------------------------------------------------------------------------
module bst_mem #(
  parameter int CAPACITY = bst_pkg::CAPACITY_DEF,
  localparam int ADDR_W  = $clog2(CAPACITY)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            addr,
  input  logic [bst_pkg::BYTE_W-1:0]   wdata,
  output logic [bst_pkg::BYTE_W-1:0]   rdata
);
  import bst_pkg::*;

  logic [BYTE_W-1:0] mem_r [CAPACITY];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bst_seq.sv
// ----------------------------------------------------------------------------
// bst_seq
// Load and read position tracking, transpose address generation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bst_seq #(
  parameter int CAPACITY = bst_pkg::CAPACITY_DEF,
  localparam int ADDR_W  = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bst_pkg::cfg_t               cfg,
  input  logic                        go,
  input  logic                        action,
  input  logic [bst_pkg::BYTE_W-1:0]  in_byte,
  output logic                        mem_en,
  output logic                        mem_we,
  output logic [ADDR_W-1:0]           mem_addr,
  output logic [bst_pkg::BYTE_W-1:0]  mem_wdata,
  output bst_pkg::rd_meta_t           meta
);
  import bst_pkg::*;

  localparam int POS_W  = $clog2(CAPACITY + 1);
  localparam int CNT_W  = ADDR_W;
  localparam int LIM_W  = COUNT_W;
  localparam int CMP_W  = (CNT_W + 1 > LIM_W) ? CNT_W + 1 : LIM_W;
  localparam int PROD_W = CNT_W + LIM_W;

  logic [POS_W-1:0]  load_pos_r, load_pos_nxt;
  logic [POS_W-1:0]  read_pos_r, read_pos_nxt;
  logic [CNT_W-1:0]  inner_r, inner_nxt;
  logic [CNT_W-1:0]  outer_r, outer_nxt;

  logic [LIM_W-1:0]  inner_lim, outer_lim;
  logic [CNT_W-1:0]  inner_e, outer_e;
  logic [CNT_W:0]    inner_inc, outer_inc;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] rd_addr;
  logic              load_ok, full, last, is_read;

  assign is_read   = (action == ACT_READ);
  assign load_ok   = cfg.ok && (TOTAL_W'(load_pos_r) < cfg.total);
  assign full      = cfg.ok && !(TOTAL_W'(load_pos_r) < cfg.total);
  assign last      = (TOTAL_W'(read_pos_r) + TOTAL_W'(1)) >= cfg.total;

  // stride equals the outer limit in both directions
  assign inner_lim = (cfg.dir == DIR_UNSHUFFLE) ? LIM_W'(cfg.size) : cfg.count;
  assign outer_lim = (cfg.dir == DIR_UNSHUFFLE) ? cfg.count : LIM_W'(cfg.size);

  assign inner_e   = (CMP_W'(inner_r) >= CMP_W'(inner_lim)) ? '0 : inner_r;
  assign outer_e   = (CMP_W'(outer_r) >= CMP_W'(outer_lim)) ? '0 : outer_r;
  assign inner_inc = {1'b0, inner_e} + (CNT_W+1)'(1);
  assign outer_inc = {1'b0, outer_e} + (CNT_W+1)'(1);

  assign prod      = PROD_W'(inner_e) * PROD_W'(outer_lim);
  assign rd_addr   = ADDR_W'(prod + PROD_W'(outer_e));

  always_comb begin
    load_pos_nxt = load_pos_r;
    read_pos_nxt = read_pos_r;
    inner_nxt    = inner_r;
    outer_nxt    = outer_r;
    if (go) begin
      if (!is_read) begin
        if (load_ok) begin
          load_pos_nxt = load_pos_r + POS_W'(1);
        end
      end else if (full) begin
        if (last) begin
          load_pos_nxt = '0;
          read_pos_nxt = '0;
          inner_nxt    = '0;
          outer_nxt    = '0;
        end else begin
          read_pos_nxt = read_pos_r + POS_W'(1);
          if (CMP_W'(inner_inc) >= CMP_W'(inner_lim)) begin
            inner_nxt = '0;
            if (CMP_W'(outer_inc) >= CMP_W'(outer_lim)) begin
              outer_nxt = '0;
            end else begin
              outer_nxt = outer_inc[CNT_W-1:0];
            end
          end else begin
            inner_nxt = inner_inc[CNT_W-1:0];
            outer_nxt = outer_e;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      read_pos_r <= '0;
      inner_r    <= '0;
      outer_r    <= '0;
    end else begin
      load_pos_r <= load_pos_nxt;
      read_pos_r <= read_pos_nxt;
      inner_r    <= inner_nxt;
      outer_r    <= outer_nxt;
    end
  end

  assign mem_en    = go && (is_read ? full : load_ok);
  assign mem_we    = go && !is_read && load_ok;
  assign mem_addr  = is_read ? rd_addr : ADDR_W'(load_pos_r);
  assign mem_wdata = in_byte;

  always_comb begin
    meta.err  = !full;
    meta.last = full && last;
  end

  `ASSERT_NEVER(a_rd_in_block, clk, rst_n, mem_en && !mem_we && (TOTAL_W'(mem_addr) >= cfg.total), "read address outside loaded block")
  `ASSERT_PROP(a_restart, clk, rst_n, go && is_read && full && last |=> (load_pos_r == '0) && (read_pos_r == '0), "block did not restart after last byte")
  `ASSERT_NEVER(a_rd_behind_ld, clk, rst_n, read_pos_r > load_pos_r, "read position ahead of load position")

endmodule

>>> test/byte_shuffle_transpose_top_tb.sv
// ----------------------------------------------------------------------------
// byte_shuffle_transpose_top_tb
// Self-checking bench for the byte shuffle/unshuffle block. Loads and reads
// are queued per phase, driven with random gaps, and every read result is
// compared with a cycle-free predictor of the byte transpose. Phases cover
// early reads, loads into a full buffer, invalid sizes, wide and long blocks
// and register changes part way through a block.
// ----------------------------------------------------------------------------
module byte_shuffle_transpose_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bst_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYC  = 8;

  typedef struct packed {
    action_t           act;
    logic [BYTE_W-1:0] data;
  } txn_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              err;
  } permuted_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bst_in_if  in_ch ();
  bst_out_if out_ch ();

  byte_shuffle_transpose_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  txn_t           txn_q[$];
  permuted_byte_t due_bytes_q[$];

  // shadow of the block: buffer, positions and registers
  logic [BYTE_W-1:0] blk_mem [CAPACITY_DEF];
  int unsigned       load_pos, inner_cnt, outer_cnt, rd_pos;
  int unsigned       sz_m, cnt_m;
  dir_t              dir_m;

  int unsigned n_queued, n_accepted, n_results, n_refused, n_ends, n_cfg;
  int unsigned fail_cnt, idle_cycles;
  int unsigned in_hold, out_hold;
  bit          in_calm, out_calm;
  txn_t        nxt;
  permuted_byte_t want;

  function automatic bit cfg_ok();
    return sz_m != 0 && sz_m <= MAX_ELEMENT_SIZE && cnt_m != 0 &&
           sz_m * cnt_m <= CAPACITY_DEF;
  endfunction

  function automatic void transpose_step(input action_t act, input logic [BYTE_W-1:0] data);
    int unsigned    total, in_lim, out_lim, stride, addr;
    bit             fin;
    permuted_byte_t res;
    total = sz_m * cnt_m;
    if (act == ACT_LOAD) begin
      if (cfg_ok() && load_pos < total) begin
        blk_mem[load_pos] = data;
        load_pos++;
      end
    end else if (!cfg_ok() || load_pos < total) begin
      res = '{value: '0, last: 1'b0, err: 1'b1};
      due_bytes_q.push_back(res);
    end else begin
      in_lim  = (dir_m == DIR_UNSHUFFLE) ? sz_m : cnt_m;
      out_lim = (dir_m == DIR_UNSHUFFLE) ? cnt_m : sz_m;
      stride  = (dir_m == DIR_UNSHUFFLE) ? cnt_m : sz_m;
      if (inner_cnt >= in_lim) inner_cnt = 0;
      if (outer_cnt >= out_lim) outer_cnt = 0;
      addr = inner_cnt * stride + outer_cnt;
      fin  = rd_pos + 1 >= total;
      res  = '{value: (addr < CAPACITY_DEF) ? blk_mem[addr] : '0, last: fin, err: 1'b0};
      due_bytes_q.push_back(res);
      if (fin) begin
        load_pos  = 0;
        inner_cnt = 0;
        outer_cnt = 0;
        rd_pos    = 0;
      end else begin
        rd_pos = (rd_pos + 1) & 32'h1FFF;
        inner_cnt++;
        if (inner_cnt >= in_lim) begin
          inner_cnt = 0;
          outer_cnt++;
          if (outer_cnt >= out_lim) outer_cnt = 0;
        end
        inner_cnt &= 32'hFFF;
        outer_cnt &= 32'hFFF;
      end
    end
  endfunction

  function automatic void push_txn(input action_t act, input logic [BYTE_W-1:0] data);
    txn_t t;
    t = '{act: act, data: data};
    txn_q.push_back(t);
    n_queued++;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.action  <= ACT_LOAD;
      in_ch.in_byte <= '0;
      in_hold = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        transpose_step(action_t'(in_ch.action), in_ch.in_byte);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_ch.valid <= 1'b0;
        end else if (txn_q.size() != 0) begin
          nxt = txn_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.action  <= nxt.act;
          in_ch.in_byte <= nxt.data;
          if ($urandom_range(0, 47) == 0) in_calm = !in_calm;
          in_hold = in_calm ? 0 : $urandom_range(0, 14);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold = 0;
    end else if (out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.out_error) n_refused++;
      if (out_ch.out_last) n_ends++;
      if (due_bytes_q.size() == 0) begin
        $error("unexpected transaction: out_byte %02h out_last %0b out_error %0b",
               out_ch.out_byte, out_ch.out_last, out_ch.out_error);
        fail_cnt++;
      end else begin
        want = due_bytes_q.pop_front();
        if (out_ch.out_byte !== want.value) begin
          $error("out_byte: expected %02h, got %02h", want.value, out_ch.out_byte);
          fail_cnt++;
        end
        if (out_ch.out_last !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_ch.out_last);
          fail_cnt++;
        end
        if (out_ch.out_error !== want.err) begin
          $error("out_error: expected %0b, got %0b", want.err, out_ch.out_error);
          fail_cnt++;
        end
      end
      if ($urandom_range(0, 47) == 0) out_calm = !out_calm;
      out_hold = out_calm ? 0 : $urandom_range(0, 14);
      out_ch.ready <= (out_hold == 0);
    end else if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= (out_hold == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
    case (idx)
      REG_ELEMENT_SIZE:  sz_m  = val & 32'h1F;
      REG_ELEMENT_COUNT: cnt_m = val & 32'h1FFF;
      REG_DIRECTION:     dir_m = dir_t'(val[0]);
      default: ;
    endcase
  endtask

  task automatic set_block(input int unsigned sz, input int unsigned cnt, input dir_t dir);
    write_reg(REG_ELEMENT_SIZE, sz);
    write_reg(REG_ELEMENT_COUNT, cnt);
    write_reg(REG_DIRECTION, dir);
  endtask

  // wait until everything queued is accepted and answered, then let loads drain
  task automatic settle();
    while (n_accepted != n_queued || due_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // mostly whole blocks (loads then reads) with random bytes, some noise
  task automatic stream_phase(input int unsigned budget, input int unsigned noise_pct);
    int unsigned total, sh_load, sh_read, n;
    bit          ok, rd;
    total   = sz_m * cnt_m;
    ok      = cfg_ok();
    sh_load = load_pos;
    sh_read = rd_pos;
    n       = 0;
    while (n < budget) begin
      if (!ok || $urandom_range(0, 99) < noise_pct) rd = 1'($urandom_range(0, 1));
      else rd = (sh_load >= total);
      push_txn(rd ? ACT_READ : ACT_LOAD, BYTE_W'($urandom_range(0, 255)));
      if (!rd) begin
        if (ok && sh_load < total) begin
          sh_load++;
          n++;
        end
      end else begin
        n++;
        if (ok && sh_load >= total) begin
          if (sh_read + 1 >= total) begin
            sh_load = 0;
            sh_read = 0;
          end else begin
            sh_read++;
          end
        end
      end
    end
    settle();
  endtask

  initial begin : stim
    int unsigned sz, cnt;
    int          ph;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_ELEMENT_SIZE;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_LOAD;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;
    sz_m      = 32'(SIZE_RST);
    cnt_m     = 32'(COUNT_RST);
    dir_m     = DIR_SHUFFLE;
    load_pos  = 0;
    inner_cnt = 0;
    outer_cnt = 0;
    rd_pos    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // default registers, nothing loaded yet
    push_txn(ACT_READ, 8'h00);
    settle();

    // small shuffle: early read, full-buffer load, then the block
    set_block(2, 2, DIR_SHUFFLE);
    push_txn(ACT_LOAD, 8'hFF);
    push_txn(ACT_READ, 8'hFF);
    push_txn(ACT_LOAD, 8'h00);
    push_txn(ACT_LOAD, 8'h5A);
    push_txn(ACT_LOAD, 8'hA5);
    push_txn(ACT_LOAD, 8'h7E);
    repeat (4) push_txn(ACT_READ, 8'h00);
    settle();

    write_reg(REG_DIRECTION, DIR_UNSHUFFLE);
    push_txn(ACT_LOAD, 8'h01);
    push_txn(ACT_LOAD, 8'h80);
    push_txn(ACT_LOAD, 8'h3C);
    push_txn(ACT_LOAD, 8'hC3);
    repeat (4) push_txn(ACT_READ, 8'h00);
    settle();

    // invalid settings: zero size, oversize, zero count, total over capacity
    write_reg(REG_ELEMENT_SIZE, 0);
    push_txn(ACT_LOAD, 8'h99);
    push_txn(ACT_READ, 8'h00);
    settle();
    write_reg(REG_ELEMENT_SIZE, 31);
    push_txn(ACT_READ, 8'h00);
    settle();
    set_block(1, 0, DIR_SHUFFLE);
    push_txn(ACT_READ, 8'h00);
    settle();
    write_reg(REG_ELEMENT_COUNT, 8191);
    push_txn(ACT_READ, 8'h00);
    settle();
    set_block(16, 4096, DIR_UNSHUFFLE);
    push_txn(ACT_READ, 8'h00);
    settle();

    // widest elements, then a long run of single-byte elements
    set_block(16, 4, DIR_SHUFFLE);
    stream_phase(128, 1);
    set_block(1, 64, DIR_UNSHUFFLE);
    stream_phase(128, 1);

    // random small blocks, now and then one over capacity; some phases only nudge one register mid-block
    for (ph = 0; ph < 14; ph++) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0: write_reg(REG_ELEMENT_SIZE, $urandom_range(1, 16));
          1: write_reg(REG_ELEMENT_COUNT, $urandom_range(1, 8));
          default: write_reg(REG_DIRECTION, $urandom_range(0, 1));
        endcase
      end else begin
        sz  = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16 : 1)
                                          : $urandom_range(1, 16);
        cnt = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 8);
        if (sz > 1 && $urandom_range(0, 9) == 0) cnt = 4096;
        set_block(sz, cnt, dir_t'($urandom_range(0, 1)));
      end
      stream_phase(30, 10);
    end

    settle();
    $display("Run covered %0d transactions and %0d checked results (%0d refused, %0d block ends)",
             n_accepted, n_results, n_refused, n_ends);
    $display("across %0d register writes: shuffle, unshuffle, wide elements and invalid sizes",
             n_cfg);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bst_pkg.sv
hw/rtl/bst_in_if.sv
hw/rtl/bst_out_if.sv
hw/rtl/bst_cfg.sv
hw/rtl/bst_mem.sv
hw/rtl/bst_seq.sv
hw/rtl/byte_shuffle_transpose_top.sv
test/byte_shuffle_transpose_top_tb.sv
